[design/bitmap_page_range_allocator_defines.svh]
// Assertion macros for the page range allocator.
// Each macro expands to one labeled concurrent assertion, or to nothing for synthesis.
`ifndef BITMAP_PAGE_RANGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_RANGE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define BPRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpra: assertion failed");
`define BPRA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpra: assertion failed");
`else
`define BPRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BPRA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[design/bpra_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bpra_pkg;

    localparam int COUNT_W   = 13;
    localparam int ADDR_W    = 48;
    localparam int STATUS_W  = 2;
    localparam int PAGES_W   = 13;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_MAX_PAGES  = 4096;
    localparam int DEF_PAGE_BYTES = 4096;

    localparam int WORD_BITS  = 64;
    localparam int WORD_IDX_W = 6;

    localparam logic [PAGES_W-1:0] HEAP_PAGES_RST = 13'd4096;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BACKING  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd3;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_PAGES = 1'd1;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic                found;
        logic [WORD_IDX_W-1:0] idx;
    } bpra_hit_t;

    typedef struct packed {
        logic                clear_wr;
        logic                load_req;
        logic                scan_init;
        logic                scan_skip;
        logic                scan_run;
        logic                zero_start;
        logic                free_init;
        logic                free_range;
        logic                upd_init;
        logic                upd_rd;
        logic                upd_wr;
        logic                load_rsp;
        logic                rsp_addr;
        logic [STATUS_W-1:0] rsp_status;
    } bpra_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic is_free;
        logic count_zero;
        logic addr_null;
        logic n_zero;
        logic backing;
        logic bad_addr;
        logic free_found;
        logic run_done;
        logic run_broken;
        logic last_row;
        logic upd_last;
    } bpra_stat_t;

    function automatic bpra_hit_t first_one(input word_t v);
        bpra_hit_t h;
        h.found = |v;
        h.idx   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                h.idx = WORD_IDX_W'(i);
            end
        end
        return h;
    endfunction

endpackage

`default_nettype wire

[design/bpra_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bpra_req_if
    import bpra_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [COUNT_W-1:0] page_count;
    logic [ADDR_W-1:0]  block_addr;
    logic               backing_ok;

    modport source (output valid, req_type, page_count, block_addr, backing_ok, input ready);
    modport sink (input valid, req_type, page_count, block_addr, backing_ok, output ready);
endinterface

interface bpra_rsp_if
    import bpra_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   alloc_addr;

    modport source (output valid, status, alloc_addr, input ready);
    modport sink (input valid, status, alloc_addr, output ready);
endinterface

`default_nettype wire

[design/bpra_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module bpra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[design/bpra_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_page_range_allocator_defines.svh"

module bpra_ctrl
    import bpra_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire bpra_stat_t stat,
    output bpra_cmd_t       cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_FRANGE = 4'd3;
    localparam logic [3:0] S_SKIP   = 4'd4;
    localparam logic [3:0] S_RUN    = 4'd5;
    localparam logic [3:0] S_UPD_RD = 4'd6;
    localparam logic [3:0] S_UPD_WR = 4'd7;
    localparam logic [3:0] S_RESP   = 4'd8;

    logic [3:0]          state_reg, state_next;
    logic [STATUS_W-1:0] code_reg, code_next;
    logic                addr_sel_reg, addr_sel_next;
    logic                out_valid_reg, out_valid_next;
    logic                rsp_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign rsp_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        addr_sel_next  = addr_sel_reg;
        cmd            = '0;
        cmd.rsp_status = code_reg;
        cmd.rsp_addr   = addr_sel_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                addr_sel_next = 1'b0;
                if (!stat.is_free)
                begin
                    if (stat.count_zero)
                    begin
                        cmd.zero_start = 1'b1;
                        code_next      = stat.n_zero ? ST_NO_SPACE : ST_OK;
                        addr_sel_next  = !stat.n_zero;
                        state_next     = S_RESP;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SKIP;
                    end
                end
                else if (stat.count_zero || stat.addr_null)
                begin
                    code_next  = ST_OK;
                    state_next = S_RESP;
                end
                else if (stat.bad_addr)
                begin
                    code_next  = ST_BAD_ADDR;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.free_init = 1'b1;
                    code_next     = ST_OK;
                    state_next    = S_FRANGE;
                end
            end
            S_FRANGE:
            begin
                cmd.free_range = 1'b1;
                state_next     = S_UPD_RD;
            end
            S_SKIP:
            begin
                cmd.scan_skip = 1'b1;
                if (stat.free_found)
                begin
                    state_next = S_RUN;
                end
                else if (stat.last_row)
                begin
                    code_next  = ST_NO_SPACE;
                    state_next = S_RESP;
                end
            end
            S_RUN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.run_done)
                begin
                    if (!stat.backing)
                    begin
                        code_next  = ST_BACKING;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        cmd.upd_init  = 1'b1;
                        code_next     = ST_OK;
                        addr_sel_next = 1'b1;
                        state_next    = S_UPD_RD;
                    end
                end
                else if (stat.run_broken)
                begin
                    state_next = S_SKIP;
                end
                else if (stat.last_row)
                begin
                    code_next  = ST_NO_SPACE;
                    state_next = S_RESP;
                end
            end
            S_UPD_RD:
            begin
                cmd.upd_rd = 1'b1;
                state_next = S_UPD_WR;
            end
            S_UPD_WR:
            begin
                cmd.upd_wr = 1'b1;
                state_next = stat.upd_last ? S_RESP : S_UPD_RD;
            end
            S_RESP:
            begin
                if (rsp_free)
                begin
                    cmd.load_rsp = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_rsp)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            code_reg      <= ST_OK;
            addr_sel_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            addr_sel_reg  <= addr_sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `BPRA_ASSERT_IMP(a_rsp_no_overwrite, clk, rst_n, cmd.load_rsp, !out_valid_reg || out_ready)
    `BPRA_ASSERT_NXT(a_one_item_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

`default_nettype wire

[design/bpra_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_page_range_allocator_defines.svh"

module bpra_dpath
    import bpra_pkg::*;
#(
    parameter int MAX_PAGES  = DEF_MAX_PAGES,
    parameter int PAGE_BYTES = DEF_PAGE_BYTES,
    localparam int ROWS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS,
    localparam int RW   = ROWS > 1 ? $clog2(ROWS) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 req_type,
    input  wire logic [COUNT_W-1:0]   page_count,
    input  wire logic [ADDR_W-1:0]    block_addr,
    input  wire logic                 backing_ok,
    input  wire bpra_cmd_t            cmd,
    output bpra_stat_t                stat,
    output logic                      ram_wr_en,
    output logic [RW-1:0]             ram_wr_addr,
    output word_t                     ram_wr_data,
    output logic                      ram_rd_en,
    output logic [RW-1:0]             ram_rd_addr,
    input  wire word_t                ram_rd_data,
    output logic [STATUS_W-1:0]       status,
    output logic [ADDR_W-1:0]         alloc_addr
);

    localparam int GW  = RW + WORD_IDX_W;
    localparam int XW  = (GW > COUNT_W ? GW : COUNT_W) + 1;
    localparam int OFS = $clog2(PAGE_BYTES);

    localparam word_t ONES = '1;

    logic [ADDR_W-1:0]     heap_base_reg;
    logic [PAGES_W-1:0]    heap_pages_reg;
    logic                  req_type_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic                  backing_reg;
    logic [RW-1:0]         row_reg;
    logic [WORD_IDX_W-1:0] off_reg;
    logic [GW-1:0]         start_reg;
    logic [GW-1:0]         lo_reg;
    logic [GW-1:0]         hi_reg;
    logic                  mark_reg;

    logic [XW-1:0]         n_x, nm1_x, row_base_x, pos_x, beyond_d, end_x, sum_x, last_x;
    logic [RW-1:0]         last_row_w, lo_row, hi_row;
    word_t                 beyond_mask, guard_mask, busy, above, range_mask, new_word;
    word_t                 lo_m, hi_m;
    bpra_hit_t             free_hit, busy_hit;
    logic                  e_in_row, run_done, adv;
    logic [ADDR_W:0]       diff;
    logic [ADDR_W-1:0]     page_of;

    assign n_x = (XW'(heap_pages_reg) > XW'(MAX_PAGES)) ? XW'(MAX_PAGES) : XW'(heap_pages_reg);
    assign nm1_x      = n_x - 1'b1;
    assign row_base_x = XW'({row_reg, {WORD_IDX_W{1'b0}}});
    assign pos_x      = XW'({row_reg, off_reg});
    assign last_row_w = (n_x == '0) ? '0 : RW'(nm1_x >> WORD_IDX_W);

    assign beyond_d = n_x - row_base_x;

    always_comb
    begin
        if (n_x <= row_base_x)
        begin
            beyond_mask = ONES;
        end
        else if (beyond_d >= XW'(WORD_BITS))
        begin
            beyond_mask = '0;
        end
        else
        begin
            beyond_mask = ONES << beyond_d[WORD_IDX_W-1:0];
        end
    end

    always_comb
    begin
        guard_mask = '0;
        if (row_reg == '0)
        begin
            guard_mask[0] = 1'b1;
        end
        if (n_x != '0 && (nm1_x >> WORD_IDX_W) == XW'(row_reg))
        begin
            guard_mask = guard_mask | (word_t'(1) << nm1_x[WORD_IDX_W-1:0]);
        end
    end

    assign busy     = ram_rd_data | beyond_mask | guard_mask;
    assign above    = ONES << off_reg;
    assign free_hit = first_one(~busy & above);
    assign busy_hit = first_one(busy & above);

    assign end_x    = XW'(start_reg) + XW'(count_reg) - 1'b1;
    assign e_in_row = (end_x >> WORD_IDX_W) == XW'(row_reg);
    assign run_done = e_in_row && (!busy_hit.found || end_x[WORD_IDX_W-1:0] < busy_hit.idx);

    assign adv = ((cmd.scan_skip && !free_hit.found) ||
                  (cmd.scan_run && !run_done && !busy_hit.found)) && (row_reg != last_row_w);

    assign diff    = {1'b0, addr_reg} - {1'b0, heap_base_reg};
    assign page_of = diff[ADDR_W-1:0] >> OFS;

    assign sum_x  = XW'(lo_reg) + XW'(count_reg);
    assign last_x = (sum_x > n_x) ? n_x : sum_x;

    assign lo_row = lo_reg[GW-1:WORD_IDX_W];
    assign hi_row = hi_reg[GW-1:WORD_IDX_W];
    assign lo_m   = (row_reg == lo_row) ? (ONES << lo_reg[WORD_IDX_W-1:0]) : ONES;
    assign hi_m   = (row_reg == hi_row) ?
                    (ONES >> (WORD_IDX_W'(WORD_BITS - 1) - hi_reg[WORD_IDX_W-1:0])) : ONES;
    assign range_mask = lo_m & hi_m;
    assign new_word   = mark_reg ? (ram_rd_data | range_mask)
                                 : (ram_rd_data & ~(range_mask & ~guard_mask));

    assign ram_wr_en   = cmd.clear_wr | cmd.upd_wr;
    assign ram_wr_addr = row_reg;
    assign ram_wr_data = cmd.clear_wr ? '0 : new_word;
    assign ram_rd_en   = cmd.scan_init | cmd.upd_rd | adv;
    assign ram_rd_addr = cmd.scan_init ? '0 : (cmd.upd_rd ? row_reg : row_reg + 1'b1);

    always_comb
    begin
        stat            = '0;
        stat.clr_done   = (row_reg == RW'(ROWS - 1));
        stat.is_free    = (req_type_reg == REQ_FREE);
        stat.count_zero = (count_reg == '0);
        stat.addr_null  = (addr_reg == '0);
        stat.n_zero     = (n_x == '0);
        stat.backing    = backing_reg;
        stat.bad_addr   = diff[ADDR_W] ||
                          ((addr_reg & ADDR_W'(PAGE_BYTES - 1)) != '0) ||
                          ({1'b0, page_of} >= (ADDR_W + 1)'(n_x));
        stat.free_found = free_hit.found;
        stat.run_done   = run_done;
        stat.run_broken = !run_done && busy_hit.found;
        stat.last_row   = (row_reg == last_row_w);
        stat.upd_last   = (row_reg == hi_row);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg  <= '0;
            heap_pages_reg <= HEAP_PAGES_RST;
            row_reg        <= '0;
            off_reg        <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_HEAP_BASE:  heap_base_reg  <= cfg_data[ADDR_W-1:0];
                    CFG_HEAP_PAGES: heap_pages_reg <= cfg_data[PAGES_W-1:0];
                    default:        ;
                endcase
            end

            if (cmd.clear_wr)
            begin
                row_reg <= stat.clr_done ? '0 : row_reg + 1'b1;
            end
            else if (cmd.scan_init)
            begin
                row_reg <= '0;
                off_reg <= '0;
            end
            else if (adv)
            begin
                row_reg <= row_reg + 1'b1;
                off_reg <= '0;
            end
            else if (cmd.scan_skip && free_hit.found)
            begin
                off_reg <= free_hit.idx;
            end
            else if (cmd.scan_run && !run_done && busy_hit.found)
            begin
                off_reg <= busy_hit.idx;
            end
            else if (cmd.upd_init)
            begin
                row_reg <= start_reg[GW-1:WORD_IDX_W];
            end
            else if (cmd.free_range)
            begin
                row_reg <= lo_row;
            end
            else if (cmd.upd_wr && !stat.upd_last)
            begin
                row_reg <= row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_type_reg <= req_type;
            count_reg    <= page_count;
            addr_reg     <= block_addr;
            backing_reg  <= backing_ok;
        end
        if (cmd.zero_start)
        begin
            start_reg <= '0;
        end
        else if (cmd.scan_skip && free_hit.found)
        begin
            start_reg <= {row_reg, free_hit.idx};
        end
        if (cmd.upd_init)
        begin
            lo_reg   <= start_reg;
            hi_reg   <= GW'(end_x);
            mark_reg <= 1'b1;
        end
        else if (cmd.free_init)
        begin
            lo_reg   <= GW'(page_of);
            mark_reg <= 1'b0;
        end
        else if (cmd.free_range)
        begin
            hi_reg <= GW'(last_x - 1'b1);
        end
        if (cmd.load_rsp)
        begin
            status     <= cmd.rsp_status;
            alloc_addr <= cmd.rsp_addr ? heap_base_reg + (ADDR_W'(start_reg) << OFS) : '0;
        end
    end

    `BPRA_ASSERT_IMP(a_upd_range_order, clk, rst_n, cmd.upd_rd, lo_reg <= hi_reg)
    `BPRA_ASSERT_IMP(a_run_start_behind_pos, clk, rst_n, cmd.scan_run, XW'(start_reg) <= pos_x)
    `BPRA_ASSERT_IMP(a_mark_spares_guards, clk, rst_n, cmd.upd_wr && mark_reg, (range_mask & guard_mask) == '0)

endmodule

`default_nettype wire

[design/bitmap_page_range_allocator.sv]
// Channel  Direction  Transfer fields
// req      in         req_type, page_count, block_addr, backing_ok
// rsp      out        status, alloc_addr
// cfg      in         cfg_wr_en, cfg_index, cfg_data (write only)
//
// One request at a time. Allocate scans the map words, stepping to each free/busy boundary, then
// marks the run with a read and a write per map word; free clears its range with a read and a write per map word.
// The scan and the read-modify-write share the single read port of the page map RAM.
// After reset a clearing pass zeroes every map word (MAX_PAGES/64 rounded up, 64 by default) before req is ready.
// The result sits in an output register; a stalled rsp holds the next result in its final state.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_range_allocator
    import bpra_pkg::*;
#(
    parameter int MAX_PAGES  = DEF_MAX_PAGES,
    parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    bpra_req_if.sink                  req,
    bpra_rsp_if.source                rsp,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int ROWS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int RW   = ROWS > 1 ? $clog2(ROWS) : 1;

    bpra_cmd_t     cmd;
    bpra_stat_t    stat;
    logic          ram_wr_en;
    logic [RW-1:0] ram_wr_addr;
    word_t         ram_wr_data;
    logic          ram_rd_en;
    logic [RW-1:0] ram_rd_addr;
    word_t         ram_rd_data;

    bpra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bpra_dpath #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_type    (req.req_type),
        .page_count  (req.page_count),
        .block_addr  (req.block_addr),
        .backing_ok  (req.backing_ok),
        .cmd         (cmd),
        .stat        (stat),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .status      (rsp.status),
        .alloc_addr  (rsp.alloc_addr)
    );

    bpra_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (ROWS)
    ) u_map (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire
